// ===== hdl/bfnn_pkg.sv =====
// bfnn_pkg: shared constants, types and helpers of the name novelty filter
// holds the bloom store geometry, the hash constants and the job beat format
// no dependencies
package bfnn_pkg;

  // bloom store geometry
  localparam int BLOOM_BITS = 2048;
  localparam int IDX_W      = $clog2(BLOOM_BITS);
  localparam int ROW_BITS   = 32;
  localparam int BIT_W      = $clog2(ROW_BITS);
  localparam int ROW_W      = IDX_W - BIT_W;
  localparam int ROWS       = (BLOOM_BITS + ROW_BITS - 1) / ROW_BITS;

  // hash constants
  localparam int          NUM_HASH  = 3;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] SEED_B    = 32'h9E3779B9;
  localparam logic [31:0] SEED_C    = 32'h85EBCA6B;
  localparam logic [31:0] HASH_INIT [NUM_HASH] = '{
    FNV_BASIS, FNV_BASIS ^ SEED_B, FNV_BASIS ^ SEED_C
  };

  // special names
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;
  localparam logic [2:0] UNKNOWN_LEN   = 3'd7;

  // job queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic [IDX_W-1:0] bloom_idx_t;

  // one job handed from the front to the back
  typedef struct packed {
    logic       collect;
    logic       skip;
    bloom_idx_t idx0;
    bloom_idx_t idx1;
    bloom_idx_t idx2;
  } job_t;

  // letters of the word "unknown"
  function automatic logic [7:0] unknown_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h75;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h6B;
      3'd3:    c = 8'h6E;
      3'd4:    c = 8'h6F;
      3'd5:    c = 8'h77;
      3'd6:    c = 8'h6E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // hash to bloom index
  function automatic bloom_idx_t hash_to_idx(input logic [31:0] h);
    bloom_idx_t m;
    m = IDX_W'(BLOOM_BITS - 1);
    return h[IDX_W-1:0] & m;
  endfunction

  // single set bit inside a row
  function automatic logic [ROW_BITS-1:0] bit_mask(input bloom_idx_t idx);
    return ROW_BITS'(1) << idx[BIT_W-1:0];
  endfunction

endpackage

// ===== hdl/bloom_filter_name_novelty_top.sv =====
// a name's last byte or a collect beat pushes a job into the 4-entry job queue, which absorbs bursts;
// empty, "unknown" or "?" names and collects are answered from IDLE, others from CHK.
// throughput: one byte per cycle while in_stall is low; the store sequencer visits
// IDLE, RD1, RD2, CHK per looked-up name (plus WR1, WR2 when new), only IDLE per collect.
// reset: synchronous; afterwards the store is cleared one 32-bit row per cycle
// (BLOOM_BITS/32 rows, 64 here) and in_stall stays high meanwhile.
module bloom_filter_name_novelty_top import bfnn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  name_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_new,
  output logic [15:0] new_name_count
);

  logic q_push;
  job_t q_push_data;
  logic q_pop;
  logic q_full;
  logic q_avail;
  job_t q_head;
  logic clearing;

  // hashing front
  bfnn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .name_byte (name_byte),
    .last      (last),
    .q_full    (q_full),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  // job queue
  bfnn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .full      (q_full),
    .avail     (q_avail),
    .head      (q_head)
  );

  // bloom store back
  bfnn_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_avail        (q_avail),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .is_new         (is_new),
    .new_name_count (new_name_count)
  );

endmodule

// ===== hdl/bfnn_front.sv =====
// bfnn_front: accepts name bytes and collect beats, runs the three hashes
// and the special-name checks, and pushes one job per finished name or collect
// depends on bfnn_pkg
module bfnn_front import bfnn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] name_byte,
  input  logic       last,
  input  logic       q_full,
  input  logic       clearing,
  output logic       q_push,
  output job_t       q_data
);

  logic [31:0] hash [NUM_HASH];
  logic [31:0] hash_next [NUM_HASH];
  logic [2:0]  match_len;
  logic [2:0]  match_len_next;
  logic        match_live;
  logic        match_live_next;
  logic        first_q;
  logic        first_q_next;
  logic [1:0]  len_sat;
  logic [1:0]  len_sat_next;
  logic        accept;
  logic        nonzero;
  logic [7:0]  folded;

  assign in_stall = q_full | clearing;
  assign accept   = in_valid & ~in_stall;
  assign nonzero  = name_byte != 8'd0;
  assign folded   = (name_byte >= 8'h41 && name_byte <= 8'h5A) ?
                    name_byte + 8'd32 : name_byte;

  // per-byte update of hashes and name checks
  always_comb begin
    for (int i = 0; i < NUM_HASH; i++) begin
      hash_next[i] = hash[i];
      if (nonzero) begin
        hash_next[i] = (hash[i] ^ {24'd0, folded}) * FNV_PRIME;
      end
    end
    match_len_next  = match_len;
    match_live_next = match_live;
    first_q_next    = first_q;
    len_sat_next    = len_sat;
    if (nonzero) begin
      if (match_live && match_len < UNKNOWN_LEN && folded == unknown_char(match_len)) begin
        match_len_next = match_len + 3'd1;
      end else begin
        match_live_next = 1'b0;
      end
      if (len_sat == 2'd0 && name_byte == CHAR_QUESTION) begin
        first_q_next = 1'b1;
      end
      if (len_sat != 2'd3) begin
        len_sat_next = len_sat + 2'd1;
      end
    end
  end

  // job beat
  assign q_push       = accept & (kind | last);
  assign q_data.collect = kind;
  assign q_data.skip  = (len_sat_next == 2'd0) ||
                        (match_live_next && match_len_next == UNKNOWN_LEN) ||
                        (first_q_next && len_sat_next == 2'd1);
  assign q_data.idx0  = hash_to_idx(hash_next[0]);
  assign q_data.idx1  = hash_to_idx(hash_next[1]);
  assign q_data.idx2  = hash_to_idx(hash_next[2]);

  // per-name state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_HASH; i++) begin
        hash[i] <= HASH_INIT[i];
      end
      match_len  <= 3'd0;
      match_live <= 1'b1;
      first_q    <= 1'b0;
      len_sat    <= 2'd0;
    end else if (accept && !kind) begin
      if (last) begin
        for (int i = 0; i < NUM_HASH; i++) begin
          hash[i] <= HASH_INIT[i];
        end
        match_len  <= 3'd0;
        match_live <= 1'b1;
        first_q    <= 1'b0;
        len_sat    <= 2'd0;
      end else begin
        for (int i = 0; i < NUM_HASH; i++) begin
          hash[i] <= hash_next[i];
        end
        match_len  <= match_len_next;
        match_live <= match_live_next;
        first_q    <= first_q_next;
        len_sat    <= len_sat_next;
      end
    end
  end

endmodule

// ===== hdl/bfnn_queue.sv =====
// bfnn_queue: short job queue between the front and the back
// depends on bfnn_pkg
module bfnn_queue import bfnn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output logic full,
  output logic avail,
  output job_t head
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W + 1)'(QDEPTH);
  assign avail = count != '0;
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== hdl/bfnn_back.sv =====
// bfnn_back: carries out jobs against the bloom store, keeps the new-name
// counter and holds the output register; clears the store after reset
// depends on bfnn_pkg
module bfnn_back import bfnn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_avail,
  input  job_t        q_head,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_new,
  output logic [15:0] new_name_count
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD1  = 3'd2;
  localparam logic [2:0] ST_RD2  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_WR1  = 3'd5;
  localparam logic [2:0] ST_WR2  = 3'd6;

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rd_data;
  logic [ROW_W-1:0]    rd_addr;
  logic                rd_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [ROW_BITS-1:0] wr_data;
  logic                wr_en;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [ROW_W-1:0]    clr_row;
  job_t                job;
  logic [ROW_BITS-1:0] d0;
  logic [ROW_BITS-1:0] d1;
  logic [ROW_BITS-1:0] m1;
  logic [ROW_BITS-1:0] m2;
  logic [ROW_BITS-1:0] m0_calc;
  logic [ROW_BITS-1:0] m1_calc;
  logic [ROW_BITS-1:0] m2_calc;
  logic [ROW_W-1:0]    row0;
  logic [ROW_W-1:0]    row1;
  logic [ROW_W-1:0]    row2;
  logic [15:0]         pending;
  logic                out_free;
  logic                known;
  logic                emit;
  logic                emit_new;
  logic                emit_collect;

  assign clearing = state == ST_CLR;
  assign out_free = ~out_valid | ~out_stall;

  assign row0 = job.idx0[IDX_W-1:BIT_W];
  assign row1 = job.idx1[IDX_W-1:BIT_W];
  assign row2 = job.idx2[IDX_W-1:BIT_W];

  // membership test and merged rows to write back
  always_comb begin
    known = d0[job.idx0[BIT_W-1:0]] & d1[job.idx1[BIT_W-1:0]] &
            rd_data[job.idx2[BIT_W-1:0]];
    m0_calc = d0 | bit_mask(job.idx0);
    m1_calc = d1 | bit_mask(job.idx1);
    m2_calc = rd_data | bit_mask(job.idx2);
    if (row1 == row0) begin
      m0_calc = m0_calc | bit_mask(job.idx1);
      m1_calc = m1_calc | bit_mask(job.idx0);
    end
    if (row2 == row0) begin
      m0_calc = m0_calc | bit_mask(job.idx2);
      m2_calc = m2_calc | bit_mask(job.idx0);
    end
    if (row2 == row1) begin
      m1_calc = m1_calc | bit_mask(job.idx2);
      m2_calc = m2_calc | bit_mask(job.idx1);
    end
  end

  // sequencer
  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = row0;
    wr_en        = 1'b0;
    wr_addr      = row0;
    wr_data      = m0_calc;
    emit         = 1'b0;
    emit_new     = 1'b0;
    emit_collect = 1'b0;
    unique case (state)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_row;
        wr_data = '0;
        if (clr_row == ROW_W'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_avail) begin
          if (q_head.collect || q_head.skip) begin
            if (out_free) begin
              q_pop        = 1'b1;
              emit         = 1'b1;
              emit_collect = q_head.collect;
            end
          end else begin
            q_pop      = 1'b1;
            rd_en      = 1'b1;
            rd_addr    = q_head.idx0[IDX_W-1:BIT_W];
            state_next = ST_RD1;
          end
        end
      end
      ST_RD1: begin
        rd_en      = 1'b1;
        rd_addr    = row1;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        rd_en      = 1'b1;
        rd_addr    = row2;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (out_free) begin
          emit = 1'b1;
          if (known) begin
            state_next = ST_IDLE;
          end else begin
            emit_new   = 1'b1;
            wr_en      = 1'b1;
            state_next = ST_WR1;
          end
        end
      end
      ST_WR1: begin
        wr_en      = 1'b1;
        wr_addr    = row1;
        wr_data    = m1;
        state_next = ST_WR2;
      end
      ST_WR2: begin
        wr_en      = 1'b1;
        wr_addr    = row2;
        wr_data    = m2;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // bloom store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // job and row holding registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
    end
    if (state == ST_RD1) begin
      d0 <= rd_data;
    end
    if (state == ST_RD2) begin
      d1 <= rd_data;
    end
    if (emit_new) begin
      m1 <= m1_calc;
      m2 <= m2_calc;
    end
  end

  // control state, counter and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_row   <= '0;
      pending   <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLR) begin
        clr_row <= clr_row + ROW_W'(1);
      end
      if (emit_collect) begin
        pending <= 16'd0;
      end else if (emit_new) begin
        pending <= pending + 16'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      is_new         <= emit_new;
      new_name_count <= emit_new ? pending + 16'd1 : pending;
    end
  end

endmodule
